// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the throttle conditioner RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled while reset is asserted.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tsc_pkg.sv =====
// ---------------------------------------------------------------------------
// tsc_pkg
// Types and constants shared by the throttle sample conditioner modules.
// ---------------------------------------------------------------------------
package tsc_pkg;

    // Field widths.
    localparam int SAMPLE_W  = 12;
    localparam int MARGIN_W  = 10;
    localparam int PCT_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_MARGIN = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [SAMPLE_W-1:0] MIN_RESET    = 12'd700;
    localparam logic [SAMPLE_W-1:0] MAX_RESET    = 12'd3450;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 10'd100;

    // Full-scale percentage.
    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    // Serial divider geometry: 20-bit dividend, 13-bit divisor, 2 bits a cycle.
    localparam int DIV_NUM_W          = 20;
    localparam int DIV_DEN_W          = 13;
    localparam int DIV_BITS_PER_CYCLE = 2;
    localparam int DIV_STEPS          = DIV_NUM_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W          = $clog2(DIV_STEPS + 1);

    // Product of a 12-bit difference and the full-scale percentage.
    localparam int PROD_W = SAMPLE_W + PCT_W;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // take the sample, update history and fault
        logic div_start;  // load the divider
        logic div_sel;    // 0: window average, 1: percentage
        logic scale;      // register the scaled difference
        logic load_out;   // load the result register
    } tsc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_busy;   // divider iterating
        logic out_free;   // result register can take a new result
    } tsc_status_t;

endpackage

// ===== src/tsc_div.sv =====
// ---------------------------------------------------------------------------
// tsc_div
// Restoring unsigned divider that retires two quotient bits per cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tsc_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tsc_pkg::DIV_NUM_W-1:0] numer,
    input  logic [tsc_pkg::DIV_DEN_W-1:0] denom,
    output logic [tsc_pkg::DIV_NUM_W-1:0] quotient,
    output logic                          busy
);
    import tsc_pkg::*;

    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_NUM_W-1:0] num_next;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] rem_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [DIV_DEN_W:0]   trial;

    // Two restoring steps: shift in a dividend bit, subtract if it fits.
    always_comb
    begin
        num_next = num_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < DIV_BITS_PER_CYCLE; i++)
        begin
            trial    = {rem_next, num_next[DIV_NUM_W-1]};
            num_next = {num_next[DIV_NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                trial       = trial - {1'b0, den_reg};
                num_next[0] = 1'b1;
            end
            rem_next = trial[DIV_DEN_W-1:0];
        end
    end

    // Step counter.
    always_comb
    begin
        priority if (start)
            cnt_next = DIV_CNT_W'(DIV_STEPS);
        else if (cnt_reg != '0)
            cnt_next = cnt_reg - 1'b1;
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // Dividend, which fills up with quotient bits, remainder and divisor.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end
        else if (cnt_reg != '0)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = num_reg;
    assign busy     = (cnt_reg != '0);

    `ASSERT_NEXT(a_div_start_busy, start, busy, "divider not busy after start")

endmodule

// ===== src/tsc_datapath.sv =====
// ---------------------------------------------------------------------------
// tsc_datapath
// Configuration registers, sample history, running sum, fault check,
// scaling and the result register of the throttle sample conditioner.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tsc_datapath
#(
    parameter int WINDOW = 10
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tsc_pkg::tsc_cmd_t             cmd,
    output tsc_pkg::tsc_status_t          status,
    input  logic                          cfg_valid,
    input  logic [tsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tsc_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic [tsc_pkg::SAMPLE_W-1:0]  raw_sample,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [tsc_pkg::PCT_W-1:0]     throttle_percent,
    output logic                          fault
);
    import tsc_pkg::*;

    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);

    logic [SAMPLE_W-1:0]  min_reg;
    logic [SAMPLE_W-1:0]  max_reg;
    logic [MARGIN_W-1:0]  margin_reg;
    logic [SAMPLE_W-1:0]  hist_reg [WINDOW];
    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]     sum_next;
    logic                 fault_reg;
    logic                 fault_next;
    logic                 zero_reg;
    logic                 zero_next;
    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    prod_next;
    logic                 out_valid_reg;
    logic [PCT_W-1:0]     pct_reg;
    logic [PCT_W-1:0]     pct_next;
    logic                 out_fault_reg;
    logic                 span_bad;
    logic [SAMPLE_W-1:0]  span;
    logic                 below_band;
    logic                 above_band;
    logic [SAMPLE_W-1:0]  avg;
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_numer;
    logic [DIV_DEN_W-1:0] div_denom;
    logic [DIV_NUM_W-1:0] div_quot;
    logic                 div_busy;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg    <= MIN_RESET;
            max_reg    <= MAX_RESET;
            margin_reg <= MARGIN_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_THROTTLE_MIN: min_reg    <= cfg_data[SAMPLE_W-1:0];
                REG_THROTTLE_MAX: max_reg    <= cfg_data[SAMPLE_W-1:0];
                REG_BOUND_MARGIN: margin_reg <= cfg_data[MARGIN_W-1:0];
                default:          ;
            endcase
        end
    end

    // Span check and guarded band check of the raw sample.
    assign span_bad   = (max_reg <= min_reg);
    assign span       = max_reg - min_reg;
    assign below_band = (min_reg >= SAMPLE_W'(margin_reg)) &&
                        (raw_sample < (min_reg - SAMPLE_W'(margin_reg)));
    assign above_band = ({1'b0, raw_sample} >
                         ({1'b0, max_reg} + (SAMPLE_W + 1)'(margin_reg)));
    assign fault_next = below_band || above_band || span_bad;

    // Running sum: drop the oldest sample, add the new one.
    assign sum_next = (sum_reg - SUM_W'(hist_reg[WINDOW-1])) + SUM_W'(raw_sample);

    // History shift line, newest sample in entry zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
                hist_reg[i] <= '0;
            sum_reg <= '0;
        end
        else if (cmd.accept)
        begin
            for (int i = WINDOW - 1; i > 0; i--)
                hist_reg[i] <= hist_reg[i-1];
            hist_reg[0] <= raw_sample;
            sum_reg     <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            fault_reg <= fault_next;
    end

    // Shared divider: window average first, then the percentage.
    assign div_start = cmd.div_start;
    assign div_numer = cmd.div_sel ? DIV_NUM_W'(prod_reg) : DIV_NUM_W'(sum_reg);
    assign div_denom = cmd.div_sel ? {1'b0, span} : DIV_DEN_W'(WINDOW);

    tsc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (div_numer),
        .denom    (div_denom),
        .quotient (div_quot),
        .busy     (div_busy)
    );

    // Scale the average above throttle_min by the full-scale percentage.
    assign avg       = div_quot[SAMPLE_W-1:0];
    assign zero_next = span_bad || (avg <= min_reg);
    assign prod_next = PROD_W'(avg - min_reg) * PROD_W'(PCT_FULL);

    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            zero_reg <= zero_next;
            prod_reg <= prod_next;
        end
    end

    // Saturate the percentage quotient at full scale; zero_reg forces zero.
    always_comb
    begin
        priority if (zero_reg)
            pct_next = '0;
        else if (div_quot > DIV_NUM_W'(PCT_FULL))
            pct_next = PCT_FULL;
        else
            pct_next = div_quot[PCT_W-1:0];
    end

    // Result register; frees up when the transaction completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            pct_reg       <= pct_next;
            out_fault_reg <= fault_reg;
        end
    end

    assign status.div_busy = div_busy;
    assign status.out_free = !out_valid_reg || result_ready;

    assign result_valid     = out_valid_reg;
    assign throttle_percent = pct_reg;
    assign fault            = out_fault_reg;

    `ASSERT_IMPLIES(a_pct_in_range, out_valid_reg, pct_reg <= PCT_FULL,
        "throttle percent above full scale")
    `ASSERT_IMPLIES(a_start_idle_div, cmd.div_start, !div_busy,
        "divider restarted while iterating")

endmodule

// ===== src/tsc_ctrl.sv =====
// ---------------------------------------------------------------------------
// tsc_ctrl
// Sequencer for the throttle sample conditioner: accept, average, scale,
// divide and hand the result to the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tsc_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  tsc_pkg::tsc_status_t status,
    output tsc_pkg::tsc_cmd_t    cmd
);
    import tsc_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_AVG_LOAD = 3'd1;
    localparam logic [2:0] ST_AVG_RUN  = 3'd2;
    localparam logic [2:0] ST_SCALE    = 3'd3;
    localparam logic [2:0] ST_PCT_LOAD = 3'd4;
    localparam logic [2:0] ST_PCT_RUN  = 3'd5;
    localparam logic [2:0] ST_EMIT     = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        sample_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_AVG_LOAD;
                end
            end
            ST_AVG_LOAD:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_AVG_RUN;
            end
            ST_AVG_RUN:
            begin
                if (!status.div_busy)
                    state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_PCT_LOAD;
            end
            ST_PCT_LOAD:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = ST_PCT_RUN;
            end
            ST_PCT_RUN:
            begin
                cmd.div_sel = 1'b1;
                if (!status.div_busy)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.div_sel = 1'b1;
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    `ASSERT_IMPLIES(a_load_when_free, cmd.load_out, status.out_free,
        "result loaded over a pending transaction")
    `ASSERT_NEXT(a_accept_starts_avg, cmd.accept, state_reg == ST_AVG_LOAD,
        "accepted sample did not start the average")

endmodule

// ===== src/throttle_sample_conditioner.sv =====
// ---------------------------------------------------------------------------
// throttle_sample_conditioner
// Fault check, moving average and percent scaling of a throttle ADC sample.
//
//   Channel   Handshake                  Payload
//   sample    sample_valid/sample_ready  raw_sample[11:0]
//   result    result_valid/result_ready  throttle_percent[6:0], fault
//   cfg       cfg_valid/cfg_ready        cfg_index[1:0], cfg_data[11:0]
//
// One sample goes from acceptance to a loaded result through two passes
// of the shared two-bits-per-cycle divider, the average and the percentage.
// The next sample is accepted the cycle after the previous result is loaded,
// even if that result still waits on result_ready; a stalled output holds
// the block in its final step. cfg_ready is always high. Reset clears the
// history to zeros and loads the default band settings at once.
// ---------------------------------------------------------------------------
module throttle_sample_conditioner
#(
    parameter int WINDOW = 10
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic [tsc_pkg::SAMPLE_W-1:0]  raw_sample,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [tsc_pkg::PCT_W-1:0]     throttle_percent,
    output logic                          fault,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tsc_pkg::CFG_DAT_W-1:0] cfg_data
);
    import tsc_pkg::*;

    tsc_cmd_t    cmd;
    tsc_status_t status;

    // Configuration writes complete every cycle.
    assign cfg_ready = 1'b1;

    tsc_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .status       (status),
        .cmd          (cmd)
    );

    tsc_datapath
    #(
        .WINDOW (WINDOW)
    )
    u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .raw_sample       (raw_sample),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .throttle_percent (throttle_percent),
        .fault            (fault)
    );

endmodule

// ===== bench/throttle_sample_conditioner_tb.sv =====
// ---------------------------------------------------------------------------
// throttle_sample_conditioner_tb
// Self-checking bench for the throttle sample conditioner. A directed table
// covers reset defaults, band edges, extreme spans, invalid spans and
// saturation. Random phases then reprogram the band and stream held levels
// with jitter. Readings are checked against an in-bench model of the fault
// check, moving average and percent scaling, or against typed table rows.
// The sender idles in bursts and the receiver stalls on changing patterns.
// ---------------------------------------------------------------------------
module throttle_sample_conditioner_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tsc_pkg::*;

    localparam int WINDOW          = 10;
    localparam int SETTLE_CYCLES   = 40;
    localparam int RANDOM_PHASES   = 13;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int REPORT_LIMIT    = 10;
    localparam int DIRECTED_ROWS   = 27;
    localparam int SAMPLE_TOP      = 4095;

    // Index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [PCT_W-1:0] percent;
        logic             fault;
    } reading_t;

    typedef enum logic [0:0] {ROW_SAMPLE, ROW_REG} row_kind_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_STARVED, RX_CADENCE} rx_mode_t;

    // One line of the directed table. Sample rows ignore the index field.
    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DAT_W-1:0]  value;
        logic [3:0]            repeats;
        logic                  typed;
        reading_t              want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  sample_valid;
    logic                  sample_ready;
    logic [SAMPLE_W-1:0]   raw_sample;
    logic                  result_valid;
    logic                  result_ready;
    logic [PCT_W-1:0]      throttle_percent;
    logic                  fault;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DAT_W-1:0]  cfg_data;

    // Band settings and sample history as the bench believes them to be.
    int unsigned           min_count;
    int unsigned           max_count;
    int unsigned           margin_count;
    logic [SAMPLE_W-1:0]   history [WINDOW];

    reading_t              awaited_readings [$];
    int                    mismatches;
    int unsigned           cycles = 0;
    int                    burst_left;
    int                    level;
    int                    n_samples;
    int                    n_directed;
    int                    n_writes;
    int                    n_settings;
    int                    n_faults;
    int                    n_full;
    rx_mode_t              rx_mode;
    int                    rx_left;

    // Directed stimulus: reset defaults, band edges, wide spans, invalid
    // spans, an ignored register index, saturation and an average that sits
    // exactly on the zero point.
    stim_row_t directed_table [DIRECTED_ROWS] = '{
        '{ROW_SAMPLE, REG_UNUSED,       12'd0,    4'd1, 1'b1, '{7'd0,   1'b1}},
        '{ROW_SAMPLE, REG_UNUSED,       12'd4095, 4'd1, 1'b1, '{7'd0,   1'b1}},
        '{ROW_SAMPLE, REG_UNUSED,       12'd600,  4'd1, 1'b1, '{7'd0,   1'b0}},
        '{ROW_SAMPLE, REG_UNUSED,       12'd599,  4'd1, 1'b1, '{7'd0,   1'b1}},
        '{ROW_SAMPLE, REG_UNUSED,       12'd3550, 4'd1, 1'b0, '{7'd0,   1'b0}},
        '{ROW_SAMPLE, REG_UNUSED,       12'd3551, 4'd1, 1'b0, '{7'd0,   1'b0}},
        '{ROW_REG,    REG_THROTTLE_MIN, 12'd0,    4'd1, 1'b0, '{7'd0,   1'b0}},
        '{ROW_REG,    REG_THROTTLE_MAX, 12'd4095, 4'd1, 1'b0, '{7'd0,   1'b0}},
        '{ROW_REG,    REG_BOUND_MARGIN, 12'hFFF,  4'd1, 1'b0, '{7'd0,   1'b0}},
        '{ROW_SAMPLE, REG_UNUSED,       12'd0,    4'd1, 1'b0, '{7'd0,   1'b0}},
        '{ROW_SAMPLE, REG_UNUSED,       12'd4095, 4'd1, 1'b0, '{7'd0,   1'b0}},
        '{ROW_REG,    REG_THROTTLE_MIN, 12'd4095, 4'd1, 1'b0, '{7'd0,   1'b0}},
        '{ROW_REG,    REG_THROTTLE_MAX, 12'd4095, 4'd1, 1'b0, '{7'd0,   1'b0}},
        '{ROW_REG,    REG_UNUSED,       12'd5,    4'd1, 1'b0, '{7'd0,   1'b0}},
        '{ROW_SAMPLE, REG_UNUSED,       12'd2048, 4'd1, 1'b1, '{7'd0,   1'b1}},
        '{ROW_REG,    REG_THROTTLE_MAX, 12'd0,    4'd1, 1'b0, '{7'd0,   1'b0}},
        '{ROW_SAMPLE, REG_UNUSED,       12'd1,    4'd1, 1'b1, '{7'd0,   1'b1}},
        '{ROW_REG,    REG_THROTTLE_MIN, 12'd0,    4'd1, 1'b0, '{7'd0,   1'b0}},
        '{ROW_REG,    REG_THROTTLE_MAX, 12'd1,    4'd1, 1'b0, '{7'd0,   1'b0}},
        '{ROW_REG,    REG_BOUND_MARGIN, 12'd0,    4'd1, 1'b0, '{7'd0,   1'b0}},
        '{ROW_SAMPLE, REG_UNUSED,       12'd4095, 4'd1, 1'b1, '{7'd100, 1'b1}},
        '{ROW_SAMPLE, REG_UNUSED,       12'd0,    4'd1, 1'b1, '{7'd100, 1'b0}},
        '{ROW_REG,    REG_THROTTLE_MIN, 12'd700,  4'd1, 1'b0, '{7'd0,   1'b0}},
        '{ROW_REG,    REG_THROTTLE_MAX, 12'd3450, 4'd1, 1'b0, '{7'd0,   1'b0}},
        '{ROW_REG,    REG_BOUND_MARGIN, 12'd100,  4'd1, 1'b0, '{7'd0,   1'b0}},
        '{ROW_SAMPLE, REG_UNUSED,       12'd700,  4'd9, 1'b0, '{7'd0,   1'b0}},
        '{ROW_SAMPLE, REG_UNUSED,       12'd700,  4'd1, 1'b1, '{7'd0,   1'b0}}
    };

    throttle_sample_conditioner #(
        .WINDOW (WINDOW)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample_valid     (sample_valid),
        .sample_ready     (sample_ready),
        .raw_sample       (raw_sample),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .throttle_percent (throttle_percent),
        .fault            (fault),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // Clock with an 8 ns period.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Applies a register write to the bench's copy of the band settings.
    function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DAT_W-1:0] data);
        case (idx)
            REG_THROTTLE_MIN: min_count = data[SAMPLE_W-1:0];
            REG_THROTTLE_MAX: max_count = data[SAMPLE_W-1:0];
            REG_BOUND_MARGIN: margin_count = data[MARGIN_W-1:0];
            default: ;
        endcase
    endfunction

    // Works out the reading one sample produces and advances the history.
    function automatic reading_t condition_sample(input logic [SAMPLE_W-1:0] s);
        reading_t    r;
        int unsigned sum;
        int unsigned avg;
        int unsigned pct;
        logic        below;
        logic        above;
        below = (min_count >= margin_count) && (s < min_count - margin_count);
        above = s > max_count + margin_count;
        r.fault = below || above;
        for (int i = WINDOW - 1; i > 0; i--)
            history[i] = history[i-1];
        history[0] = s;
        pct = 0;
        if (max_count > min_count)
        begin
            sum = 0;
            for (int i = 0; i < WINDOW; i++)
                sum += history[i];
            avg = sum / WINDOW;
            if (avg > min_count)
                pct = (PCT_FULL * (avg - min_count)) / (max_count - min_count);
            if (pct > PCT_FULL)
                pct = PCT_FULL;
        end
        else
        begin
            // A span that is empty or inverted always reads zero with a fault.
            r.fault = 1'b1;
        end
        r.percent = pct[PCT_W-1:0];
        return r;
    endfunction

    // Random sample: mostly a held level with a little jitter, so the average
    // settles; the level jumps now and then to band edges, set points or
    // the rails, and a few samples are pure noise.
    function automatic logic [SAMPLE_W-1:0] next_sample();
        int v;
        int lower;
        int upper;
        lower = int'(min_count) - int'(margin_count);
        upper = int'(max_count + margin_count);
        if ($urandom_range(0, 9) == 0)
        begin
            case ($urandom_range(0, 6))
                0: level = 0;
                1: level = SAMPLE_TOP;
                2: level = lower + int'($urandom_range(0, 4)) - 2;
                3: level = upper + int'($urandom_range(0, 4)) - 2;
                4: level = int'(min_count);
                5: level = int'(max_count);
                default: level = int'($urandom_range(0, SAMPLE_TOP));
            endcase
        end
        if ($urandom_range(0, 7) == 0)
            v = int'($urandom_range(0, SAMPLE_TOP));
        else
            v = level + int'($urandom_range(0, 6)) - 3;
        if (v < 0)
            v = 0;
        if (v > SAMPLE_TOP)
            v = SAMPLE_TOP;
        return v[SAMPLE_W-1:0];
    endfunction

    // Sender pacing: runs of back-to-back samples broken by random gaps.
    // Payload carries noise while valid is low.
    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        gap = $urandom_range(1, 32);
        sample_valid <= 1'b0;
        repeat (gap)
        begin
            raw_sample <= SAMPLE_W'($urandom);
            @(posedge clk);
        end
        if ($urandom_range(0, 3) == 0)
            burst_left = $urandom_range(40, 80);
        else
            burst_left = $urandom_range(0, 16);
    endtask

    // Offers one sample, waits for the transaction, then records the reading
    // it should produce.
    task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic typed,
                               input reading_t want);
        reading_t modeled;
        sample_valid <= 1'b1;
        raw_sample   <= s;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        modeled = condition_sample(s);
        awaited_readings.push_back(typed ? want : modeled);
        n_samples++;
        pace();
    endtask

    // Stops the sender, lets every outstanding reading arrive, then gives
    // the block time to go fully idle.
    task automatic settle();
        sample_valid <= 1'b0;
        burst_left = 0;
        while (awaited_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        store_reg(idx, data);
        n_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Main stimulus.
    initial
    begin : stimulus
        int lo;
        int hi;
        int mg;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        raw_sample   = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_THROTTLE_MIN;
        cfg_data     = '0;
        min_count    = MIN_RESET;
        max_count    = MAX_RESET;
        margin_count = MARGIN_RESET;
        for (int i = 0; i < WINDOW; i++)
            history[i] = '0;
        mismatches = 0;
        burst_left = 0;
        level      = 0;
        n_samples  = 0;
        n_writes   = 0;
        n_settings = 1;
        n_faults   = 0;
        n_full     = 0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        foreach (directed_table[r])
        begin
            if (directed_table[r].kind == ROW_REG)
            begin
                settle();
                write_reg(directed_table[r].index, directed_table[r].value);
                n_settings++;
            end
            else
            begin
                for (int k = 0; k < directed_table[r].repeats; k++)
                    push_sample(directed_table[r].value[SAMPLE_W-1:0],
                                directed_table[r].typed &&
                                (k == directed_table[r].repeats - 1),
                                directed_table[r].want);
            end
        end
        n_directed = n_samples;

        // Random phases, each under a fresh band setting.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: begin lo = 0;    hi = SAMPLE_TOP; mg = 0;    end
                1: begin lo = SAMPLE_TOP; hi = 0;    mg = 1023; end
                2: begin lo = 0;    hi = 1;          mg = 1023; end
                3: begin lo = 4094; hi = SAMPLE_TOP; mg = 1;    end
                default:
                begin
                    lo = $urandom_range(0, 3500);
                    if ($urandom_range(0, 7) == 0)
                        hi = $urandom_range(0, lo);
                    else
                        hi = $urandom_range(lo + 1, SAMPLE_TOP);
                    mg = $urandom_range(0, 1023);
                end
            endcase
            settle();
            write_reg(REG_THROTTLE_MIN, lo[CFG_DAT_W-1:0]);
            write_reg(REG_THROTTLE_MAX, hi[CFG_DAT_W-1:0]);
            // Bits above the margin width ride along and must be dropped.
            write_reg(REG_BOUND_MARGIN,
                      {2'($urandom_range(0, 3)), mg[MARGIN_W-1:0]});
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_UNUSED, CFG_DAT_W'($urandom));
            n_settings++;
            level = ($urandom_range(0, 1) == 0) ? lo : hi;
            repeat (ITEMS_PER_PHASE)
                push_sample(next_sample(), 1'b0, '0);
        end

        settle();
        $display("%0d samples conditioned (%0d directed) under %0d band settings, %0d writes.",
                 n_samples, n_directed, n_settings, n_writes);
        $display("%0d readings carried a fault, %0d sat at full scale, %0d mismatches.",
                 n_faults, n_full, mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Result side: stall pattern changes at random intervals, and each
    // transaction is checked against the oldest awaited reading.
    always @(posedge clk)
    begin : receiver
        reading_t got;
        reading_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                got.percent = throttle_percent;
                got.fault   = fault;
                if (got.fault === 1'b1)
                    n_faults++;
                if (got.percent === PCT_FULL)
                    n_full++;
                if (awaited_readings.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected reading: percent %0d fault %0b",
                                 got.percent, got.fault);
                end
                else
                begin
                    want = awaited_readings.pop_front();
                    if (got.percent !== want.percent || got.fault !== want.fault)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("reading mismatch: expected percent %0d fault %0b, got percent %0d fault %0b",
                                     want.percent, want.fault, got.percent, got.fault);
                    end
                end
            end
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(8, 64);
            end
            else
            begin
                rx_left--;
            end
            case (rx_mode)
                RX_OPEN:     result_ready <= 1'b1;
                RX_COIN:     result_ready <= 1'($urandom_range(0, 1));
                RX_STARVED:  result_ready <= ($urandom_range(0, 7) == 0);
                RX_CADENCE:  result_ready <= ((cycles % 5) < 2);
                default:     result_ready <= 1'b1;
            endcase
        end
        else
        begin
            rx_mode = RX_OPEN;
            rx_left = 0;
            result_ready <= 1'b0;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d readings still awaited",
                     cycles, awaited_readings.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/tsc_pkg.sv
src/tsc_div.sv
src/tsc_datapath.sv
src/tsc_ctrl.sv
src/throttle_sample_conditioner.sv
bench/throttle_sample_conditioner_tb.sv
